// ===== src/langant_pkg.sv =====
package langant_pkg;

  // Request kinds carried on s_axis_tuser
  typedef enum logic [1:0] {
    KIND_STEP  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_PLACE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    HEAD_UP    = 2'd0,
    HEAD_RIGHT = 2'd1,
    HEAD_DOWN  = 2'd2,
    HEAD_LEFT  = 2'd3
  } heading_e;

  // Config register indexes
  typedef enum logic [1:0] {
    REG_HEIGHT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_ON     = 2'd2,
    REG_OFF    = 2'd3
  } reg_idx_e;

  localparam int CoordW = 6;
  localparam int DimW   = 7;
  localparam int PixW   = 32;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    heading_e          heading;
  } ant_t;

  // Clamp a size register to 1..lim
  function automatic logic [DimW-1:0] eff_dim(logic [DimW-1:0] v, logic [DimW-1:0] lim);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== src/langant_grid_ram.sv =====
module langant_grid_ram #(
  parameter int AddrW = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic             wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic             rdata_o,
  output logic             clr_busy_o
);

  localparam int Depth = 2 ** AddrW;

  logic             mem_q [Depth];
  logic             rdata_q;
  logic             clr_busy_q, clr_busy_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic             mem_wdata;

  // Clearing sweep after reset, one cell per cycle
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == {AddrW{1'b1}}) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign mem_we    = clr_busy_q | we_i;
  assign mem_waddr = clr_busy_q ? clr_addr_q : waddr_i;
  assign mem_wdata = clr_busy_q ? 1'b0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_busy_q;

endmodule

// ===== src/langant_step_logic.sv =====
module langant_step_logic (
  input  langant_pkg::kind_e                    kind_i,
  input  logic [langant_pkg::CoordW-1:0]        row_i,
  input  logic [langant_pkg::CoordW-1:0]        col_i,
  input  logic                                  cell_value_i,
  input  langant_pkg::heading_e                 heading_in_i,
  input  langant_pkg::ant_t                     ant_i,
  input  logic [langant_pkg::DimW-1:0]          height_i,
  input  logic [langant_pkg::DimW-1:0]          width_i,
  input  logic                                  cell_i,
  output langant_pkg::ant_t                     ant_o,
  output logic                                  we_o,
  output logic                                  wdata_o,
  output logic                                  alive_o,
  output logic                                  error_o
);

  logic                           ant_out;
  logic                           req_out;
  langant_pkg::heading_e          turn;
  logic [langant_pkg::DimW-1:0]   row_inc;
  logic [langant_pkg::DimW-1:0]   col_inc;
  logic [langant_pkg::DimW-1:0]   h_last;
  logic [langant_pkg::DimW-1:0]   w_last;
  langant_pkg::ant_t              moved;

  assign ant_out = ({1'b0, ant_i.row} >= height_i) || ({1'b0, ant_i.col} >= width_i);
  assign req_out = ({1'b0, row_i} >= height_i) || ({1'b0, col_i} >= width_i);

  // live cell: turn left, dead cell: turn right
  assign turn    = cell_i ? langant_pkg::heading_e'(ant_i.heading + 2'd3)
                          : langant_pkg::heading_e'(ant_i.heading + 2'd1);
  assign row_inc = {1'b0, ant_i.row} + langant_pkg::DimW'(1);
  assign col_inc = {1'b0, ant_i.col} + langant_pkg::DimW'(1);
  assign h_last  = height_i - langant_pkg::DimW'(1);
  assign w_last  = width_i - langant_pkg::DimW'(1);

  always_comb begin
    moved         = ant_i;
    moved.heading = turn;
    unique case (turn)
      langant_pkg::HEAD_UP: begin
        moved.row = (row_inc >= height_i) ? '0 : row_inc[langant_pkg::CoordW-1:0];
      end
      langant_pkg::HEAD_RIGHT: begin
        moved.col = (col_inc >= width_i) ? '0 : col_inc[langant_pkg::CoordW-1:0];
      end
      langant_pkg::HEAD_DOWN: begin
        moved.row = (ant_i.row == '0) ? h_last[langant_pkg::CoordW-1:0]
                                      : ant_i.row - langant_pkg::CoordW'(1);
      end
      default: begin
        moved.col = (ant_i.col == '0) ? w_last[langant_pkg::CoordW-1:0]
                                      : ant_i.col - langant_pkg::CoordW'(1);
      end
    endcase
  end

  always_comb begin
    ant_o   = ant_i;
    we_o    = 1'b0;
    wdata_o = 1'b0;
    alive_o = 1'b0;
    error_o = 1'b0;
    unique case (kind_i)
      langant_pkg::KIND_STEP: begin
        if (ant_out) begin
          error_o = 1'b1;
        end else begin
          ant_o   = moved;
          we_o    = 1'b1;
          wdata_o = ~cell_i;
          alive_o = ~cell_i;
        end
      end
      langant_pkg::KIND_READ: begin
        error_o = req_out;
        alive_o = !req_out && cell_i;
      end
      langant_pkg::KIND_WRITE: begin
        error_o = req_out;
        we_o    = !req_out;
        wdata_o = cell_value_i;
        alive_o = !req_out && cell_value_i;
      end
      default: begin
        error_o = req_out;
        alive_o = !req_out && cell_i;
        if (!req_out) begin
          ant_o.row     = row_i;
          ant_o.col     = col_i;
          ant_o.heading = heading_in_i;
        end
      end
    endcase
  end

endmodule

// ===== src/langton_ant_grid_stepper_top.sv =====
// Langton's ant on a one-bit grid, driven by a request stream.
// Slave side: s_axis_tuser is the request kind (step, read cell, write cell,
// place ant), s_axis_tdata carries row, col, cell_value and heading_in.
// Master side: one result per request with the cell state, its pixel value,
// the ant position and heading afterwards, and the error flag in tuser.
// Config: cfg_we_i writes grid_height, grid_width, on_value or off_value
// selected by cfg_idx_i; write only while no request is in flight.
// Timing: the accepting edge registers the request and reads the cell from the
// grid RAM (registered read); once the output register is free, a later edge
// updates cell, ant and result register.
// The next request is taken only once the read-modify-write has retired, so
// a new request is never taken while one is in flight; m_axis_tvalid is set
// by the edge that retires the request.
// Reset: the grid RAM is swept to dead, one cell per cycle, across all
// 2**(clog2(min(MAX_ROWS,64)) + clog2(min(MAX_COLS,64))) cells (4096 by
// default); s_axis_tready stays low during the sweep. The ant sits at row 0,
// column 0, heading up.
// Stall: a result waits in the output register; a request may still be taken
// and read, but it retires only when the output register is free.
module langton_ant_grid_stepper_top #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // row[5:0], col[11:6], cell_value[12], heading_in[14:13]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // cell_alive[0], pixel_value[32:1], ant_row[38:33],
                                      // ant_col[44:39], ant_heading[46:45]
  output logic        m_axis_tuser,   // error[0]
  // config writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int RowLim = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int ColLim = (MAX_COLS < 64) ? MAX_COLS : 64;
  localparam int RowW   = $clog2(RowLim);
  localparam int ColW   = $clog2(ColLim);
  localparam int AddrW  = RowW + ColW;

  localparam logic [langant_pkg::DimW-1:0] RowLimV = langant_pkg::DimW'(RowLim);
  localparam logic [langant_pkg::DimW-1:0] ColLimV = langant_pkg::DimW'(ColLim);

  // config registers
  logic [langant_pkg::DimW-1:0] height_q, width_q;
  logic [langant_pkg::PixW-1:0] on_q, off_q;
  logic [langant_pkg::DimW-1:0] h_eff, w_eff;

  // request stage
  logic                              busy_q;
  langant_pkg::kind_e                kind_q;
  logic [langant_pkg::CoordW-1:0]    row_q, col_q;
  logic                              val_q;
  langant_pkg::heading_e             hin_q;
  logic [AddrW-1:0]                  addr_q;

  // ant state and result register
  langant_pkg::ant_t                 ant_q, ant_d;
  logic                              out_valid_q;
  logic [47:0]                       out_data_q;
  logic                              out_err_q;

  logic                              in_accept;
  logic                              fire;
  logic                              clr_busy;
  logic                              cell_rd;
  logic                              mem_we;
  logic                              step_we;
  logic                              step_wdata;
  logic                              step_alive;
  logic                              step_err;
  logic [AddrW-1:0]                  rd_addr;
  langant_pkg::kind_e                in_kind;
  logic [langant_pkg::CoordW-1:0]    in_row, in_col;
  logic [langant_pkg::PixW-1:0]      pixel;

  assign in_kind = langant_pkg::kind_e'(s_axis_tuser);
  assign in_row  = s_axis_tdata[5:0];
  assign in_col  = s_axis_tdata[11:6];

  assign h_eff = langant_pkg::eff_dim(height_q, RowLimV);
  assign w_eff = langant_pkg::eff_dim(width_q, ColLimV);

  // one request in flight at a time; the ant position is final when taken
  assign s_axis_tready = !clr_busy && !busy_q;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign fire          = busy_q && (!out_valid_q || m_axis_tready);

  // cells live at {row, col}; out-of-grid addresses are read but never written
  assign rd_addr = (in_kind == langant_pkg::KIND_STEP)
                 ? {ant_q.row[RowW-1:0], ant_q.col[ColW-1:0]}
                 : {in_row[RowW-1:0], in_col[ColW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= langant_pkg::DimW'(64);
      width_q  <= langant_pkg::DimW'(64);
      on_q     <= langant_pkg::PixW'(1);
      off_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (langant_pkg::reg_idx_e'(cfg_idx_i))
        langant_pkg::REG_HEIGHT: height_q <= cfg_data_i[langant_pkg::DimW-1:0];
        langant_pkg::REG_WIDTH:  width_q  <= cfg_data_i[langant_pkg::DimW-1:0];
        langant_pkg::REG_ON:     on_q     <= cfg_data_i;
        default:                 off_q    <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= in_kind;
      row_q  <= in_row;
      col_q  <= in_col;
      val_q  <= s_axis_tdata[12];
      hin_q  <= langant_pkg::heading_e'(s_axis_tdata[14:13]);
      addr_q <= rd_addr;
    end
  end

  langant_grid_ram #(
    .AddrW (AddrW)
  ) u_grid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (mem_we),
    .waddr_i    (addr_q),
    .wdata_i    (step_wdata),
    .re_i       (in_accept),
    .raddr_i    (rd_addr),
    .rdata_o    (cell_rd),
    .clr_busy_o (clr_busy)
  );

  langant_step_logic u_step (
    .kind_i       (kind_q),
    .row_i        (row_q),
    .col_i        (col_q),
    .cell_value_i (val_q),
    .heading_in_i (hin_q),
    .ant_i        (ant_q),
    .height_i     (h_eff),
    .width_i      (w_eff),
    .cell_i       (cell_rd),
    .ant_o        (ant_d),
    .we_o         (step_we),
    .wdata_o      (step_wdata),
    .alive_o      (step_alive),
    .error_o      (step_err)
  );

  assign mem_we = fire && step_we;
  assign pixel  = step_err ? '0 : (step_alive ? on_q : off_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      ant_q       <= '{row: '0, col: '0, heading: langant_pkg::HEAD_UP};
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        busy_q <= 1'b1;
      end else if (fire) begin
        busy_q <= 1'b0;
      end
      if (fire) begin
        ant_q       <= ant_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {1'b0, ant_d.heading, ant_d.col, ant_d.row, pixel, step_alive};
      out_err_q  <= step_err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

`ifndef ASSERT_OFF
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> busy_q && !s_axis_tready)
    else $error("request taken but stage not busy");

  a_result_from_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(busy_q))
    else $error("result appeared without a request in flight");

  a_no_write_on_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !in_accept)
    else $error("grid write collides with grid read");

  a_ant_row_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !step_err |=> ({1'b0, ant_q.row} < RowLimV) && ({1'b0, ant_q.col} < ColLimV))
    else $error("ant left the storable grid");
`endif

endmodule

// ===== tb/sv/langton_ant_result_checker.sv =====
module langton_ant_result_checker
  import langant_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // row[5:0], col[11:6], cell_value[12], heading_in[14:13]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // cell_alive[0], pixel_value[32:1], ant_row[38:33],
                                      // ant_col[44:39], ant_heading[46:45]
  input  logic        m_axis_tuser,   // error[0]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output int          mismatches_o,
  output int          outstanding_o,
  output int          checked_o,
  output int          flagged_o
);

  localparam int RowLim   = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int ColLim   = (MAX_COLS < 64) ? MAX_COLS : 64;
  localparam int NumCells = MAX_ROWS * MAX_COLS;
  localparam int PrintMax = 20;

  typedef struct packed {
    logic        alive;
    logic [31:0] pixel;
    logic [5:0]  row;
    logic [5:0]  col;
    heading_e    heading;
    logic        err;
  } cell_result_t;

  // shadow of the block
  logic        grid_q [NumCells];
  logic [5:0]  ant_row;
  logic [5:0]  ant_col;
  heading_e    ant_head;
  logic [6:0]  height_q;
  logic [6:0]  width_q;
  logic [31:0] on_q;
  logic [31:0] off_q;

  cell_result_t expected_results [$];
  int mismatch_cnt = 0;
  int checked_cnt  = 0;
  int flagged_cnt  = 0;

  function automatic int unsigned clamp_dim(logic [6:0] v, int unsigned lim);
    if (v == 7'd0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  // Applies one request to the shadow state, returns the result it should produce.
  function automatic cell_result_t apply_request(kind_e k, logic [5:0] r, logic [5:0] c,
                                                 logic v, heading_e hd);
    cell_result_t res;
    int unsigned  h;
    int unsigned  w;
    int unsigned  idx;
    logic         flipped;
    h   = clamp_dim(height_q, RowLim);
    w   = clamp_dim(width_q, ColLim);
    res = '0;
    if (k == KIND_STEP) begin
      if (ant_row >= h || ant_col >= w) begin
        res.err = 1'b1;
      end else begin
        idx         = ant_row * MAX_COLS + ant_col;
        flipped     = ~grid_q[idx];
        grid_q[idx] = flipped;
        // newly live: turn right, newly dead: turn left
        ant_head = flipped ? heading_e'(ant_head + 2'd1) : heading_e'(ant_head + 2'd3);
        case (ant_head)
          HEAD_UP:    ant_row = (int'(ant_row) + 1 >= h) ? 6'd0 : ant_row + 6'd1;
          HEAD_RIGHT: ant_col = (int'(ant_col) + 1 >= w) ? 6'd0 : ant_col + 6'd1;
          HEAD_DOWN:  ant_row = (ant_row == 6'd0) ? 6'(h - 1) : ant_row - 6'd1;
          default:    ant_col = (ant_col == 6'd0) ? 6'(w - 1) : ant_col - 6'd1;
        endcase
        res.alive = flipped;
      end
    end else if (r >= h || c >= w) begin
      res.err = 1'b1;
    end else begin
      idx = r * MAX_COLS + c;
      if (k == KIND_WRITE) begin
        grid_q[idx] = v;
      end else if (k == KIND_PLACE) begin
        ant_row  = r;
        ant_col  = c;
        ant_head = hd;
      end
      res.alive = grid_q[idx];
    end
    if (!res.err) begin
      res.pixel = res.alive ? on_q : off_q;
    end
    res.row     = ant_row;
    res.col     = ant_col;
    res.heading = ant_head;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= PrintMax) begin
      $display("mismatch %0d on result %0d: %s got 0x%0h expected 0x%0h",
               mismatch_cnt, checked_cnt, what, got, want);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cell_result_t got;
    cell_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NumCells; i++) grid_q[i] = 1'b0;
      ant_row  = '0;
      ant_col  = '0;
      ant_head = HEAD_UP;
      height_q = 7'd64;
      width_q  = 7'd64;
      on_q     = 32'd1;
      off_q    = 32'd0;
      expected_results.delete();
    end else begin
      // results first: nothing accepted this edge can already have its result out
      if (m_axis_tvalid && m_axis_tready) begin
        got.alive   = m_axis_tdata[0];
        got.pixel   = m_axis_tdata[32:1];
        got.row     = m_axis_tdata[38:33];
        got.col     = m_axis_tdata[44:39];
        got.heading = heading_e'(m_axis_tdata[46:45]);
        got.err     = m_axis_tuser;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request pending", got.pixel, '0);
        end else begin
          want = expected_results.pop_front();
          if (got.alive !== want.alive) begin
            report_mismatch("cell_alive", 32'(got.alive), 32'(want.alive));
          end
          if (got.pixel !== want.pixel) report_mismatch("pixel_value", got.pixel, want.pixel);
          if (got.row !== want.row) report_mismatch("ant_row", 32'(got.row), 32'(want.row));
          if (got.col !== want.col) report_mismatch("ant_col", 32'(got.col), 32'(want.col));
          if (got.heading !== want.heading) begin
            report_mismatch("ant_heading", 32'(got.heading), 32'(want.heading));
          end
          if (got.err !== want.err) report_mismatch("error", 32'(got.err), 32'(want.err));
          if (want.err) flagged_cnt++;
        end
        checked_cnt++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_request(kind_e'(s_axis_tuser), s_axis_tdata[5:0],
                                                 s_axis_tdata[11:6], s_axis_tdata[12],
                                                 heading_e'(s_axis_tdata[14:13])));
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_HEIGHT: height_q = cfg_data_i[6:0];
          REG_WIDTH:  width_q  = cfg_data_i[6:0];
          REG_ON:     on_q     = cfg_data_i;
          default:    off_q    = cfg_data_i;
        endcase
      end
    end
    mismatches_o  <= mismatch_cnt;
    outstanding_o <= expected_results.size();
    checked_o     <= checked_cnt;
    flagged_o     <= flagged_cnt;
  end

endmodule

// ===== tb/sv/langton_ant_grid_stepper_top_tb.sv =====
module langton_ant_grid_stepper_top_tb;
  import langant_pkg::*;

  // Run bounds. The grid sweep after reset comes first; each request can at
  // worst see a sender gap, the block's read and update and a long receiver
  // stall, plus one long hold-off. The limit is several times that total.
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 400;
  localparam int PerPhase   = 305;
  localparam int Settle     = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  int mismatches;
  int outstanding;
  int checked;
  int flagged;

  // stimulus-side bookkeeping
  int          burst_left = 0;
  int          kind_cnt [4] = '{0, 0, 0, 0};
  int          settings_cnt = 0;
  int unsigned cur_h = 64;
  int unsigned cur_w = 64;
  logic        hold_req = 1'b0;
  logic        hold_off = 1'b0;
  int          cycle_cnt = 0;

  always #6 clk_i = ~clk_i;

  langton_ant_grid_stepper_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Watches both streams and the config port, predicts and compares.
  langton_ant_result_checker ant_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .flagged_o     (flagged)
  );

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_cnt, outstanding);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Long receiver hold-off, armed once by the stimulus. The sender keeps
  // offering requests meanwhile, so the output register fills and the block
  // has to drop s_axis_tready.
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Receiver: stretches of random length, each with its own stall pattern
  // (always ready, coin flip, mostly stalled, periodic).
  initial begin
    int unsigned seg_len;
    int unsigned rx_mode;
    int unsigned tick;
    logic        rdy;
    m_axis_tready = 1'b0;
    tick = 0;
    forever begin
      seg_len = $urandom_range(20, 200);
      rx_mode = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(posedge clk_i);
        tick++;
        case (rx_mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          2:       rdy = ($urandom_range(0, 7) == 0);
          default: rdy = (tick % 3 != 0);
        endcase
        m_axis_tready <= rdy && !hold_off;
      end
    end
  end

  // Offers one request and returns at the edge where it is taken. The sender
  // runs in bursts; between bursts it may idle.
  task automatic send_request(kind_e k, logic [5:0] r, logic [5:0] c, logic v, heading_e hd);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, hd, v, c, r};
    s_axis_tuser  <= k;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    kind_cnt[k]++;
  endtask

  // Half of the requests are steps; coordinates mostly inside the grid in use, the rest anywhere.
  task automatic random_request();
    int unsigned pick;
    kind_e       k;
    logic [5:0]  r;
    logic [5:0]  c;
    pick = $urandom_range(0, 99);
    if (pick < 50) k = KIND_STEP;
    else if (pick < 70) k = KIND_READ;
    else if (pick < 85) k = KIND_WRITE;
    else k = KIND_PLACE;
    if ($urandom_range(0, 9) < 8) begin
      r = 6'($urandom_range(0, cur_h - 1));
      c = 6'($urandom_range(0, cur_w - 1));
    end else begin
      r = 6'($urandom);
      c = 6'($urandom);
    end
    send_request(k, r, c, 1'($urandom), heading_e'(2'($urandom)));
  endtask

  // Stop offering and wait until every request has its result back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Writes all four registers back to back; only called with the block idle.
  task automatic program_grid(logic [6:0] h, logic [6:0] w, logic [31:0] on_v,
                              logic [31:0] off_v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_HEIGHT;
    cfg_data_i <= 32'(h);
    @(posedge clk_i);
    cfg_idx_i  <= REG_WIDTH;
    cfg_data_i <= 32'(w);
    @(posedge clk_i);
    cfg_idx_i  <= REG_ON;
    cfg_data_i <= on_v;
    @(posedge clk_i);
    cfg_idx_i  <= REG_OFF;
    cfg_data_i <= off_v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_h = (h == 0) ? 1 : ((h > 64) ? 64 : h);
    cur_w = (w == 0) ? 1 : ((w > 64) ? 64 : w);
    settings_cnt++;
  endtask

  task automatic random_phase(logic [6:0] h, logic [6:0] w, logic [31:0] on_v,
                              logic [31:0] off_v, logic with_hold);
    program_grid(h, w, on_v, off_v);
    for (int i = 0; i < PerPhase; i++) begin
      if (with_hold && i == 60) hold_req = 1'b1;
      random_request();
    end
    drain();
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_STEP;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_HEIGHT;
    cfg_data_i    = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    settings_cnt = 1;

    // Directed, default 64x64 grid. Requests wait out the clearing sweep on
    // s_axis_tready. Corners first, then a walk that wraps the ant off every edge.
    send_request(KIND_READ,  6'd0,  6'd0,  1'b0, HEAD_UP);
    send_request(KIND_READ,  6'd63, 6'd63, 1'b0, HEAD_UP);
    send_request(KIND_WRITE, 6'd63, 6'd63, 1'b1, HEAD_LEFT);
    send_request(KIND_READ,  6'd63, 6'd63, 1'b0, HEAD_UP);
    send_request(KIND_WRITE, 6'd0,  6'd63, 1'b1, HEAD_UP);
    send_request(KIND_WRITE, 6'd63, 6'd0,  1'b0, HEAD_UP);
    send_request(KIND_PLACE, 6'd0,  6'd0,  1'b0, HEAD_DOWN);
    // dead cell, right turn to left, column wraps to 63
    send_request(KIND_STEP,  6'd0,  6'd0,  1'b0, HEAD_UP);
    // live cell, left turn to down, row wraps to 63
    send_request(KIND_STEP,  6'd0,  6'd0,  1'b0, HEAD_UP);
    // live cell, left turn to right, column wraps to 0
    send_request(KIND_STEP,  6'd0,  6'd0,  1'b0, HEAD_UP);
    send_request(KIND_STEP,  6'd0,  6'd0,  1'b0, HEAD_UP);
    send_request(KIND_PLACE, 6'd63, 6'd63, 1'b1, HEAD_UP);
    send_request(KIND_STEP,  6'd63, 6'd63, 1'b1, HEAD_RIGHT);
    // live cell from the walk above, left turn to up, row wraps to 0
    send_request(KIND_STEP,  6'd42, 6'd21, 1'b1, HEAD_DOWN);
    send_request(KIND_PLACE, 6'd42, 6'd21, 1'b1, HEAD_LEFT);
    send_request(KIND_PLACE, 6'd21, 6'd42, 1'b0, HEAD_RIGHT);
    drain();

    // Shrink under the ant: it now sits outside the grid, so a step is flagged,
    // and coordinates past either edge are refused. The ant is then placed inside and steps.
    program_grid(7'd8, 7'd8, 32'h8000_0001, 32'h7fff_fffe);
    send_request(KIND_STEP,  6'd0,  6'd0,  1'b0, HEAD_UP);
    send_request(KIND_READ,  6'd8,  6'd0,  1'b0, HEAD_UP);
    send_request(KIND_WRITE, 6'd0,  6'd8,  1'b1, HEAD_UP);
    send_request(KIND_PLACE, 6'd63, 6'd63, 1'b0, HEAD_LEFT);
    send_request(KIND_READ,  6'd7,  6'd7,  1'b0, HEAD_UP);
    send_request(KIND_PLACE, 6'd7,  6'd7,  1'b0, HEAD_DOWN);
    send_request(KIND_STEP,  6'd0,  6'd0,  1'b0, HEAD_UP);
    drain();

    // Random phases across size extremes (zero and oversize values clamp)
    // and pixel value extremes. The third phase carries the long hold-off.
    random_phase(7'd127, 7'd64, 32'hffff_ffff, 32'h0000_0000, 1'b0);
    random_phase(7'd1, 7'd0, $urandom, $urandom, 1'b0);
    random_phase(7'd5, 7'd7, $urandom, $urandom, 1'b1);
    random_phase(7'd64, 7'd1, 32'h0000_0000, 32'hffff_ffff, 1'b0);
    random_phase(7'd2, 7'd65, $urandom, $urandom, 1'b0);
    random_phase(7'd64, 7'd64, $urandom, $urandom, 1'b0);

    repeat (Settle) @(posedge clk_i);

    $display("covered %0d steps, %0d reads, %0d writes, %0d places under %0d grid settings",
             kind_cnt[KIND_STEP], kind_cnt[KIND_READ], kind_cnt[KIND_WRITE],
             kind_cnt[KIND_PLACE], settings_cnt);
    $display("%0d results compared, %0d flagged out of grid, %0d mismatches",
             checked, flagged, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/langant_pkg.sv
src/langant_grid_ram.sv
src/langant_step_logic.sv
src/langton_ant_grid_stepper_top.sv
tb/sv/langton_ant_result_checker.sv
tb/sv/langton_ant_grid_stepper_top_tb.sv
